### rtl/core/mmt_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, operation and mode codes, and the structs that travel
// from the top level and the sequencer into the multiply-accumulate cells.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int ELEM_W   = 8;
    localparam int IDX_BITS = 3;
    localparam int DIM_W    = 4;
    localparam int MODE_W   = 2;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LEFT_TRANS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT_TRANS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_seq_state;

    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic                last;
        logic [ELEM_W-1:0]   sum;
    } t_tok;

    typedef struct packed {
        logic                left_en;
        logic                right_en;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [ELEM_W-1:0]   value;
    } t_wr;

    typedef struct packed {
        logic             a_trans;
        logic             b_trans;
        logic [DIM_W-1:0] inner;
    } t_cell_ctl;

endpackage

### rtl/core/mmt_cell.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate cell
// Holds row and column K of both matrices, multiplies the element pair for
// the passing product element and, if K < inner, adds it to its partial sum.
// ----------------------------------------------------------------------------
module mmt_cell #(
    parameter int MAX_DIM = 8,
    parameter int K       = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mmt_pkg::t_wr       i_wr,
    input  mmt_pkg::t_cell_ctl i_ctl,
    input  mmt_pkg::t_tok      i_tok,
    output mmt_pkg::t_tok      o_tok
);
    import mmt_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [ELEM_W-1:0] r_lcol [MAX_DIM];
    logic [ELEM_W-1:0] r_lrow [MAX_DIM];
    logic [ELEM_W-1:0] r_rrow [MAX_DIM];
    logic [ELEM_W-1:0] r_rcol [MAX_DIM];

    logic [ELEM_W-1:0] a_val;
    logic [ELEM_W-1:0] b_val;
    logic [ELEM_W-1:0] prod;
    logic              use_k;
    t_tok              n_tok;
    t_tok              r_tok;

    always_ff @(posedge i_clk) begin
        if (i_wr.left_en) begin
            if (i_wr.col == IDX_BITS'(K)) begin
                r_lcol[i_wr.row[IDX_W-1:0]] <= i_wr.value;
            end
            if (i_wr.row == IDX_BITS'(K)) begin
                r_lrow[i_wr.col[IDX_W-1:0]] <= i_wr.value;
            end
        end
        if (i_wr.right_en) begin
            if (i_wr.row == IDX_BITS'(K)) begin
                r_rrow[i_wr.col[IDX_W-1:0]] <= i_wr.value;
            end
            if (i_wr.col == IDX_BITS'(K)) begin
                r_rcol[i_wr.row[IDX_W-1:0]] <= i_wr.value;
            end
        end
    end

    always_comb begin
        a_val = i_ctl.a_trans ? r_lrow[i_tok.row[IDX_W-1:0]] : r_lcol[i_tok.row[IDX_W-1:0]];
        b_val = i_ctl.b_trans ? r_rcol[i_tok.col[IDX_W-1:0]] : r_rrow[i_tok.col[IDX_W-1:0]];
        prod  = a_val * b_val;
        use_k = DIM_W'(K) < i_ctl.inner;
        n_tok = i_tok;
        if (use_k) begin
            n_tok.sum = i_tok.sum + prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.row  <= n_tok.row;
        r_tok.col  <= n_tok.col;
        r_tok.last <= n_tok.last;
        r_tok.sum  <= n_tok.sum;
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/mmt_seq.sv
// ----------------------------------------------------------------------------
// Product element sequencer
// Walks the product in row-major order, issuing one element a cycle into
// the cell chain, then waits for the chain to drain.
// ----------------------------------------------------------------------------
module mmt_seq #(
    parameter int MAX_DIM = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [mmt_pkg::DIM_W-1:0] i_rows,
    input  logic [mmt_pkg::DIM_W-1:0] i_cols,
    output mmt_pkg::t_tok             o_tok,
    output logic                      o_busy
);
    import mmt_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_seq_state          r_state;
    t_seq_state          n_state;
    logic [IDX_BITS-1:0] r_i;
    logic [IDX_BITS-1:0] n_i;
    logic [IDX_BITS-1:0] r_j;
    logic [IDX_BITS-1:0] n_j;
    logic [IDX_W-1:0]    r_drain;
    logic [IDX_W-1:0]    n_drain;
    logic                row_end;
    logic                col_end;

    assign row_end = (DIM_W'(r_i) + DIM_W'(1)) == i_rows;
    assign col_end = (DIM_W'(r_j) + DIM_W'(1)) == i_cols;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_drain = r_drain;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go && (i_rows != '0) && (i_cols != '0)) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            ST_RUN: begin
                if (row_end && col_end) begin
                    n_state = ST_DRAIN;
                    n_drain = IDX_W'(MAX_DIM - 1);
                end else if (col_end) begin
                    n_j = '0;
                    n_i = r_i + IDX_BITS'(1);
                end else begin
                    n_j = r_j + IDX_BITS'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_drain = r_drain - IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_tok.valid = (r_state == ST_RUN);
        o_tok.row   = r_i;
        o_tok.col   = r_j;
        o_tok.last  = row_end && col_end;
        o_tok.sum   = '0;
        o_busy      = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_drain <= n_drain;
        end
    end

endmodule

### rtl/core/matrix_multiply_transpose_modes.sv
// ----------------------------------------------------------------------------
// Integer matrix multiply with transpose modes
// Loads two signed 8-bit matrices element by element and streams their
// product, wrapped to 8 bits, in row-major order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load requests
// (left or right element) are written in that cycle and produce no result;
// busy stays low, so loads can be issued every cycle. A compute request
// with nonzero rows and cols raises busy on the next cycle, else it does
// nothing. Elements then enter a chain of MAX_DIM multiply-accumulate
// cells, one per cycle, and cell K adds one inner-sum term if K < inner.
// Results follow one per cycle; busy falls once the chain has drained.
// Each result is shown for one cycle with o_result_valid high and
// o_last_result marks the final element. The receiver cannot stall the
// block. Configuration must be written through i_cfg_we, i_cfg_index and
// i_cfg_data only while busy is low; the block does not enforce this.
// Reset returns the registers to mode 0 and all sizes 1 and clears the
// chain; the matrix stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_multiply_transpose_modes #(
    parameter int MAX_DIM = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mmt_pkg::OP_W-1:0]            i_operation,
    input  logic [mmt_pkg::IDX_BITS-1:0]        i_row_index,
    input  logic [mmt_pkg::IDX_BITS-1:0]        i_col_index,
    input  logic signed [mmt_pkg::ELEM_W-1:0]   i_elem_value,
    input  logic                                i_cfg_we,
    input  logic [mmt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmt_pkg::DIM_W-1:0]           i_cfg_data,
    output logic                                o_result_valid,
    output logic [mmt_pkg::IDX_BITS-1:0]        o_out_row,
    output logic [mmt_pkg::IDX_BITS-1:0]        o_out_col,
    output logic signed [mmt_pkg::ELEM_W-1:0]   o_product_value,
    output logic                                o_last_result
);
    import mmt_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  r_rows;
    logic [DIM_W-1:0]  r_inner;
    logic [DIM_W-1:0]  r_cols;
    logic [DIM_W-1:0]  rows_c;
    logic [DIM_W-1:0]  inner_c;
    logic [DIM_W-1:0]  cols_c;
    logic              accept;
    logic              in_range;
    logic              go;
    t_wr               wr;
    t_cell_ctl         ctl;
    t_tok              tok [MAX_DIM+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_rows  <= DIM_W'(1);
            r_inner <= DIM_W'(1);
            r_cols  <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_INNER: r_inner <= i_cfg_data;
                CFG_COLS:  r_cols  <= i_cfg_data;
            endcase
        end
    end

    assign rows_c  = (r_rows  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_rows;
    assign inner_c = (r_inner > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_inner;
    assign cols_c  = (r_cols  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cols;

    assign accept   = start && !busy;
    assign in_range = (DIM_W'(i_row_index) < DIM_W'(MAX_DIM))
                   && (DIM_W'(i_col_index) < DIM_W'(MAX_DIM));
    assign go       = accept && (i_operation == OP_COMPUTE);

    always_comb begin
        wr.left_en  = accept && in_range && (i_operation == OP_LOAD_LEFT);
        wr.right_en = accept && in_range && (i_operation == OP_LOAD_RIGHT);
        wr.row      = i_row_index;
        wr.col      = i_col_index;
        wr.value    = i_elem_value;
        ctl.a_trans = (r_mode == MODE_LEFT_TRANS);
        ctl.b_trans = (r_mode == MODE_RIGHT_TRANS);
        ctl.inner   = inner_c;
    end

    mmt_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_rows  (rows_c),
        .i_cols  (cols_c),
        .o_tok   (tok[0]),
        .o_busy  (busy)
    );

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mmt_cell #(
            .MAX_DIM (MAX_DIM),
            .K       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_ctl   (ctl),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign o_result_valid  = tok[MAX_DIM].valid;
    assign o_out_row       = tok[MAX_DIM].row;
    assign o_out_col       = tok[MAX_DIM].col;
    assign o_product_value = tok[MAX_DIM].sum;
    assign o_last_result   = tok[MAX_DIM].last;

endmodule

### tb/tb_matrix_multiply_transpose_modes.sv
// ----------------------------------------------------------------------------
// Matrix multiply with transpose modes testbench
// Loads both matrices element by element, computes products under every
// transpose mode and a range of sizes, and checks each streamed product
// element against a behavioral predictor of the wrapped sum of products.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_transpose_modes;
    import mmt_pkg::*;

    localparam int MAX_DIM      = 8;
    localparam int ITEM_TARGET  = 270;
    localparam int DRAIN_CYCLES = MAX_DIM + 4;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [ELEM_W-1:0]   value;
        int                  gap;
        bit                  hold;
    } t_request;

    typedef struct {
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [ELEM_W-1:0]   value;
        logic                last;
    } t_product;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [OP_W-1:0]             operation = '0;
    logic [IDX_BITS-1:0]         row_index = '0;
    logic [IDX_BITS-1:0]         col_index = '0;
    logic signed [ELEM_W-1:0]    elem_value = '0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [DIM_W-1:0]            cfg_data = '0;
    logic                        result_valid;
    logic [IDX_BITS-1:0]         out_row;
    logic [IDX_BITS-1:0]         out_col;
    logic signed [ELEM_W-1:0]    product_value;
    logic                        last_result;

    t_request pending_reqs[$];
    t_product product_q[$];
    t_request cur_req;
    t_product head_product;
    bit       have_req = 1'b0;
    int       gap_left = 0;
    logic     req_taken = 1'b0;
    int       stall_cycles = 0;
    int       mismatch_count = 0;

    // Predictor copy of the matrix stores and the configuration registers.
    logic [ELEM_W-1:0] left_mem [MAX_DIM][MAX_DIM];
    logic [ELEM_W-1:0] right_mem [MAX_DIM][MAX_DIM];
    logic [MODE_W-1:0] mode_reg = MODE_PLAIN;
    logic [DIM_W-1:0]  rows_reg = 1;
    logic [DIM_W-1:0]  inner_reg = 1;
    logic [DIM_W-1:0]  cols_reg = 1;

    // Stimulus side: which entries hold data, and the settings being applied.
    bit                left_set [MAX_DIM][MAX_DIM];
    bit                right_set [MAX_DIM][MAX_DIM];
    logic [MODE_W-1:0] gen_mode = MODE_PLAIN;
    int                gen_rows = 1;
    int                gen_inner = 1;
    int                gen_cols = 1;
    bit                no_gaps = 1'b0;
    int                reqs_queued = 0;

    matrix_multiply_transpose_modes #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (operation),
        .i_row_index     (row_index),
        .i_col_index     (col_index),
        .i_elem_value    (elem_value),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_result_valid  (result_valid),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_product_value (product_value),
        .o_last_result   (last_result)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int saturate(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic void predict_products();
        int                rows;
        int                inner;
        int                cols;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] acc;
        t_product          p;
        rows  = saturate(rows_reg);
        inner = saturate(inner_reg);
        cols  = saturate(cols_reg);
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                acc = '0;
                for (int k = 0; k < inner; k++) begin
                    case (mode_reg)
                        MODE_LEFT_TRANS: begin
                            a = left_mem[k][i];
                            b = right_mem[k][j];
                        end
                        MODE_RIGHT_TRANS: begin
                            a = left_mem[i][k];
                            b = right_mem[j][k];
                        end
                        default: begin
                            a = left_mem[i][k];
                            b = right_mem[k][j];
                        end
                    endcase
                    acc = acc + a * b;
                end
                p.row   = IDX_BITS'(i);
                p.col   = IDX_BITS'(j);
                p.value = acc;
                p.last  = (i == rows - 1) && (j == cols - 1);
                product_q.push_back(p);
            end
        end
    endfunction

    function automatic void queue_request(input logic [OP_W-1:0] op, input int row, input int col,
                                          input logic [ELEM_W-1:0] value, input bit hold);
        t_request r;
        r.op    = op;
        r.row   = IDX_BITS'(row);
        r.col   = IDX_BITS'(col);
        r.value = value;
        r.gap   = no_gaps ? 0 : $urandom_range(0, 14);
        r.hold  = hold;
        pending_reqs.push_back(r);
        if (op == OP_LOAD_LEFT) begin
            left_set[row][col] = 1'b1;
        end
        if (op == OP_LOAD_RIGHT) begin
            right_set[row][col] = 1'b1;
        end
        if (op != OP_UNUSED) begin
            reqs_queued++;
        end
    endfunction

    // Every operand that the compute request reads is loaded first if it never was.
    function automatic void queue_compute(input bit hold);
        int r;
        int c;
        if (gen_rows > 0 && gen_cols > 0) begin
            for (int i = 0; i < gen_rows; i++) begin
                for (int k = 0; k < gen_inner; k++) begin
                    r = (gen_mode == MODE_LEFT_TRANS) ? k : i;
                    c = (gen_mode == MODE_LEFT_TRANS) ? i : k;
                    if (!left_set[r][c]) begin
                        queue_request(OP_LOAD_LEFT, r, c, ELEM_W'($urandom_range(0, 255)), 1'b0);
                    end
                end
            end
            for (int k = 0; k < gen_inner; k++) begin
                for (int j = 0; j < gen_cols; j++) begin
                    r = (gen_mode == MODE_RIGHT_TRANS) ? j : k;
                    c = (gen_mode == MODE_RIGHT_TRANS) ? k : j;
                    if (!right_set[r][c]) begin
                        queue_request(OP_LOAD_RIGHT, r, c, ELEM_W'($urandom_range(0, 255)), 1'b0);
                    end
                end
            end
        end
        queue_request(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                      ELEM_W'($urandom_range(0, 255)), hold);
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return 0;
        end else if (roll < 3) begin
            return $urandom_range(8, 15);
        end
        return $urandom_range(1, 4);
    endfunction

    task automatic wait_quiet();
        do @(posedge clk); while (pending_reqs.size() != 0 || have_req || start);
        do @(negedge clk); while (product_q.size() != 0 || busy);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [MODE_W-1:0] mode, input int rows, input int inner,
                                input int cols);
        logic [DIM_W-1:0] mode_data;
        wait_quiet();
        mode_data = DIM_W'($urandom_range(0, 15));
        mode_data[MODE_W-1:0] = mode;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= mode_data;
        @(negedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= DIM_W'(rows);
        @(negedge clk);
        cfg_index <= CFG_INNER;
        cfg_data  <= DIM_W'(inner);
        @(negedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= DIM_W'(cols);
        @(negedge clk);
        cfg_we    <= 1'b0;
        gen_mode  = mode;
        gen_rows  = saturate(DIM_W'(rows));
        gen_inner = saturate(DIM_W'(inner));
        gen_cols  = saturate(DIM_W'(cols));
        @(posedge clk);
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (!have_req && pending_reqs.size() > 0) begin
                cur_req  = pending_reqs.pop_front();
                have_req = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_req && gap_left == 0 && (!cur_req.hold || product_q.size() == 0)) begin
                start      <= 1'b1;
                operation  <= cur_req.op;
                row_index  <= cur_req.row;
                col_index  <= cur_req.col;
                elem_value <= cur_req.value;
                have_req   = 1'b0;
            end else begin
                start <= 1'b0;
                if (have_req && gap_left > 0) begin
                    gap_left--;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            req_taken    <= 1'b0;
            stall_cycles <= 0;
        end else begin
            req_taken <= start && !busy;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MODE:  mode_reg  = cfg_data[MODE_W-1:0];
                    CFG_ROWS:  rows_reg  = cfg_data;
                    CFG_INNER: inner_reg = cfg_data;
                    CFG_COLS:  cols_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (operation)
                    OP_LOAD_LEFT:  left_mem[row_index][col_index] = elem_value;
                    OP_LOAD_RIGHT: right_mem[row_index][col_index] = elem_value;
                    OP_COMPUTE:    predict_products();
                    default: ;
                endcase
            end
            if (result_valid) begin
                if (product_q.size() == 0) begin
                    $error("product element (%0d,%0d) with no request pending", out_row, out_col);
                    mismatch_count++;
                end else begin
                    head_product = product_q.pop_front();
                    if (out_row !== head_product.row) begin
                        $error("out_row: expected %0d, actual %0d", head_product.row, out_row);
                        mismatch_count++;
                    end
                    if (out_col !== head_product.col) begin
                        $error("out_col: expected %0d, actual %0d", head_product.col, out_col);
                        mismatch_count++;
                    end
                    if (product_value !== head_product.value) begin
                        $error("product_value: expected %0d, actual %0d",
                               $signed(head_product.value), product_value);
                        mismatch_count++;
                    end
                    if (last_result !== head_product.last) begin
                        $error("last_result: expected %0d, actual %0d",
                               head_product.last, last_result);
                        mismatch_count++;
                    end
                end
            end
            if ((start && !busy) || result_valid || cfg_we) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL matrix_multiply_transpose_modes");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int n;
        int pick;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        write_config(MODE_PLAIN, 1, 1, 1);

        // Element extremes on a single-element product; the unused operation must not write.
        queue_request(OP_LOAD_LEFT, 0, 0, 8'h7f, 1'b0);
        queue_request(OP_LOAD_RIGHT, 0, 0, 8'h7f, 1'b0);
        queue_compute(1'b0);
        queue_request(OP_LOAD_LEFT, 0, 0, 8'h80, 1'b0);
        queue_compute(1'b0);
        queue_request(OP_LOAD_RIGHT, 0, 0, 8'h80, 1'b0);
        queue_compute(1'b1);
        queue_request(OP_UNUSED, 0, 0, 8'h01, 1'b0);
        queue_request(OP_UNUSED, 7, 7, 8'hfe, 1'b0);
        queue_compute(1'b0);
        queue_request(OP_LOAD_LEFT, 7, 7, 8'h00, 1'b0);
        queue_request(OP_LOAD_RIGHT, 7, 7, 8'hff, 1'b0);

        // Zero rows, zero columns, zero inner size, and the unused mode value.
        write_config(MODE_PLAIN, 0, 3, 2);
        queue_compute(1'b0);
        write_config(MODE_RIGHT_TRANS, 2, 2, 0);
        queue_compute(1'b0);
        write_config(MODE_UNUSED, 2, 0, 3);
        queue_compute(1'b0);
        write_config(MODE_UNUSED, 2, 2, 2);
        queue_compute(1'b0);

        // Full-size product with oversized dimensions that saturate.
        write_config(MODE_LEFT_TRANS, 15, 8, 15);
        queue_compute(1'b0);

        while (reqs_queued < ITEM_TARGET) begin
            write_config(MODE_W'($urandom_range(0, 3)), pick_dim(), pick_dim(), pick_dim());
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(3, 10);
            repeat (n) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    queue_compute($urandom_range(0, 5) == 0);
                end else if (pick == 2) begin
                    queue_request(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                  ELEM_W'($urandom_range(0, 255)), 1'b0);
                end else begin
                    queue_request($urandom_range(0, 1) ? OP_LOAD_LEFT : OP_LOAD_RIGHT,
                                  $urandom_range(0, 7), $urandom_range(0, 7),
                                  ELEM_W'($urandom_range(0, 255)), 1'b0);
                end
            end
            queue_compute($urandom_range(0, 5) == 0);
        end

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("PASS matrix_multiply_transpose_modes");
        end else begin
            $display("FAIL matrix_multiply_transpose_modes");
        end
        $finish;
    end

endmodule
